// ----- design/hfpcd_pkg.sv -----
// shared types, constants and character decode helpers for the hex frame parser
// depends on nothing; used by the interfaces, the result emitter and the top level
package hfpcd_pkg;

    localparam int PAYLOAD_BYTES = 16;
    localparam int IDX_W         = $clog2(PAYLOAD_BYTES);
    localparam int ADDR_W        = IDX_W + 1;
    localparam int MASK_W        = 10;

    // frame positions
    localparam logic [5:0] POS_HUNT    = 6'd0;
    localparam logic [5:0] POS_SEEN7   = 6'd1;
    localparam logic [5:0] POS_PAYLOAD = 6'd2;
    localparam logic [5:0] POS_END     = 6'd36;
    localparam logic [5:0] POS_LAST    = 6'd39;

    localparam logic [7:0] CHAR_SEVEN  = 8'h37;
    localparam logic [7:0] CHAR_E      = 8'h65;
    localparam logic [7:0] XOR_INIT    = 8'h7e;
    localparam logic [7:0] THR_RESET   = 8'd2;

    localparam logic [IDX_W-1:0] IDX_LAST  = IDX_W'(PAYLOAD_BYTES - 1);
    localparam logic [4:0]       DIG_BYTES = 5'd7;

    typedef struct packed {
        logic              start;
        logic              bank;
        logic              ok;
        logic [MASK_W-1:0] mask;
    } emit_req_t;

    function automatic logic [3:0] hex_val(input logic [7:0] c);
        logic [7:0] d;
        begin
            d = 8'h00;
            case (c) inside
                [8'h30:8'h39]: d = c - 8'h30;
                [8'h61:8'h66]: d = c - 8'h57;
                [8'h41:8'h46]: d = c - 8'h37;
                default:       d = 8'h00;
            endcase
            return d[3:0];
        end
    endfunction

    // expected ending "0d0a"; frame position 36 is a multiple of four
    function automatic logic [7:0] end_char(input logic [1:0] e);
        logic [7:0] r;
        begin
            case (e)
                2'd0:    r = 8'h30;
                2'd1:    r = 8'h64;
                2'd2:    r = 8'h30;
                default: r = 8'h61;
            endcase
            return r;
        end
    endfunction

    function automatic logic [5:0] start_candidate(input logic [7:0] c);
        return (c == CHAR_SEVEN) ? POS_SEEN7 : POS_HUNT;
    endfunction

endpackage

// ----- design/hfpcd_if.sv -----
// valid/ready channel interfaces: received characters in, decoded payload bytes out
// depends on hfpcd_pkg for field widths
interface hfpcd_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_char;

    modport source (output valid, output rx_char, input ready);
    modport sink   (input valid, input rx_char, output ready);
endinterface

interface hfpcd_res_if;
    logic                           valid;
    logic                           ready;
    logic [hfpcd_pkg::IDX_W-1:0]    byte_index;
    logic [7:0]                     payload_byte;
    logic                           last_of_frame;
    logic                           checksum_ok;
    logic [hfpcd_pkg::MASK_W-1:0]   change_mask;

    modport source (output valid, output byte_index, output payload_byte,
                    output last_of_frame, output checksum_ok, output change_mask,
                    input ready);
    modport sink   (input valid, input byte_index, input payload_byte,
                    input last_of_frame, input checksum_ok, input change_mask,
                    output ready);
endinterface

// ----- design/hex_frame_parser_change_detect.sv -----
// output: a frame's first beat follows its final character through the emitter's active
// and the store read registers, then 16 byte beats, one per cycle while the sink is ready
// throughput: one character per cycle; input stalls only on a frame's final character
// when the previous frame's 16 beats are still being emitted (one emitter, one bank pair)
// reset: asynchronous active low; hunting for the start mark, previous bytes read as zero
// until the first well-framed frame, threshold 2; no clearing pass
module hex_frame_parser_change_detect
(
    input  logic        clk,
    input  logic        rst_n,
    hfpcd_rx_if.sink    rx,
    hfpcd_res_if.source res,
    input  logic        cfg_we,
    input  logic [7:0]  cfg_data
);

    logic [5:0]                     pos_reg,  pos_next;
    logic [3:0]                     hi_reg,   hi_next;
    logic [7:0]                     xor_reg,  xor_next;
    logic [7:0]                     cs_reg,   cs_next;
    logic [hfpcd_pkg::MASK_W-1:0]   mask_reg, mask_next;
    logic                           wr_bank_reg, wr_bank_next;
    logic                           prev_valid_reg, prev_valid_next;
    logic [7:0]                     thr_reg;

    // byte store: two banks, one filling, the other holding the last well-framed frame
    logic [7:0]                     mem [2*hfpcd_pkg::PAYLOAD_BYTES];
    logic [7:0]                     rd_emit_reg;
    logic [7:0]                     rd_prev_reg;
    logic                           we;
    logic [hfpcd_pkg::ADDR_W-1:0]   waddr;
    logic [7:0]                     wdata;
    logic                           rd_prev_en;
    logic [hfpcd_pkg::ADDR_W-1:0]   rd_prev_addr;
    logic                           rd_emit_en;
    logic [hfpcd_pkg::ADDR_W-1:0]   rd_emit_addr;

    hfpcd_pkg::emit_req_t           req;
    logic                           emit_busy;
    logic                           accept;
    logic [7:0]                     c;
    logic [3:0]                     nib;
    logic [5:0]                     k;
    logic [4:0]                     idx;
    logic [7:0]                     b;
    logic [7:0]                     p;
    logic [7:0]                     diff;
    logic                           far;

    assign rx.ready = !((pos_reg == hfpcd_pkg::POS_LAST) && emit_busy);
    assign accept   = rx.valid && rx.ready;
    assign c        = rx.rx_char;
    assign nib      = hfpcd_pkg::hex_val(c);
    assign k        = pos_reg - hfpcd_pkg::POS_PAYLOAD;
    assign idx      = k[5:1];
    assign b        = {hi_reg, nib};
    assign p        = prev_valid_reg ? rd_prev_reg : 8'h00;
    assign diff     = (b > p) ? (b - p) : (p - b);
    assign far      = diff > thr_reg;

    always_comb
    begin
        pos_next        = pos_reg;
        hi_next         = hi_reg;
        xor_next        = xor_reg;
        cs_next         = cs_reg;
        mask_next       = mask_reg;
        wr_bank_next    = wr_bank_reg;
        prev_valid_next = prev_valid_reg;
        we              = 1'b0;
        waddr           = {wr_bank_reg, idx[hfpcd_pkg::IDX_W-1:0]};
        wdata           = b;
        rd_prev_en      = 1'b0;
        rd_prev_addr    = {!wr_bank_reg, idx[hfpcd_pkg::IDX_W-1:0]};
        req.start       = 1'b0;
        req.bank        = wr_bank_reg;
        req.ok          = (xor_reg == cs_reg);
        req.mask        = (xor_reg == cs_reg) ? mask_reg : '0;
        if (accept)
        begin
            if (pos_reg == hfpcd_pkg::POS_HUNT)
            begin
                pos_next = hfpcd_pkg::start_candidate(c);
            end
            else if (pos_reg == hfpcd_pkg::POS_SEEN7)
            begin
                if (c == hfpcd_pkg::CHAR_E)
                begin
                    pos_next  = hfpcd_pkg::POS_PAYLOAD;
                    xor_next  = hfpcd_pkg::XOR_INIT;
                    hi_next   = 4'h0;
                    mask_next = '0;
                end
                else
                begin
                    pos_next = hfpcd_pkg::start_candidate(c);
                end
            end
            else if (pos_reg < hfpcd_pkg::POS_END)
            begin
                pos_next = pos_reg + 6'd1;
                if (!k[0])
                begin
                    hi_next = nib;
                    // fetch the previous value now, it is compared on the low digit
                    rd_prev_en = (idx < 5'(hfpcd_pkg::PAYLOAD_BYTES));
                end
                else if (idx < 5'(hfpcd_pkg::PAYLOAD_BYTES))
                begin
                    we       = 1'b1;
                    xor_next = xor_reg ^ b;
                    if (idx < hfpcd_pkg::DIG_BYTES)
                    begin
                        mask_next[idx[2:0]] = mask_reg[idx[2:0]] | (b != p);
                    end
                    case (idx) inside
                        [5'd7:5'd9]:   mask_next[7] = mask_reg[7] | far;
                        [5'd10:5'd12]: mask_next[8] = mask_reg[8] | far;
                        [5'd13:5'd15]: mask_next[9] = mask_reg[9] | far;
                        default:       ;
                    endcase
                end
                else
                begin
                    cs_next = b;
                end
            end
            else if (pos_reg <= hfpcd_pkg::POS_LAST)
            begin
                if (c != hfpcd_pkg::end_char(pos_reg[1:0]))
                begin
                    pos_next = hfpcd_pkg::start_candidate(c);
                end
                else if (pos_reg < hfpcd_pkg::POS_LAST)
                begin
                    pos_next = pos_reg + 6'd1;
                end
                else
                begin
                    // frame done: the filled bank becomes the previous frame
                    pos_next        = hfpcd_pkg::POS_HUNT;
                    req.start       = 1'b1;
                    wr_bank_next    = !wr_bank_reg;
                    prev_valid_next = 1'b1;
                end
            end
            else
            begin
                pos_next = hfpcd_pkg::start_candidate(c);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg        <= hfpcd_pkg::POS_HUNT;
            hi_reg         <= 4'h0;
            xor_reg        <= hfpcd_pkg::XOR_INIT;
            cs_reg         <= 8'h00;
            mask_reg       <= '0;
            wr_bank_reg    <= 1'b0;
            prev_valid_reg <= 1'b0;
            thr_reg        <= hfpcd_pkg::THR_RESET;
        end
        else
        begin
            pos_reg        <= pos_next;
            hi_reg         <= hi_next;
            xor_reg        <= xor_next;
            cs_reg         <= cs_next;
            mask_reg       <= mask_next;
            wr_bank_reg    <= wr_bank_next;
            prev_valid_reg <= prev_valid_next;
            if (cfg_we)
            begin
                thr_reg <= cfg_data;
            end
        end
    end

    // writes go to the filling bank, both reads to the other one, so no forwarding
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (rd_emit_en)
        begin
            rd_emit_reg <= mem[rd_emit_addr];
        end
        if (rd_prev_en)
        begin
            rd_prev_reg <= mem[rd_prev_addr];
        end
    end

    hfpcd_emitter u_emitter
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req),
        .busy    (emit_busy),
        .rd_en   (rd_emit_en),
        .rd_addr (rd_emit_addr),
        .rd_data (rd_emit_reg),
        .res     (res)
    );

    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= hfpcd_pkg::POS_LAST)
        else $error("frame position out of range");

    a_no_bank_clash: assert property (@(posedge clk) disable iff (!rst_n)
        (we && rd_emit_en) |-> (waddr[hfpcd_pkg::ADDR_W-1] != rd_emit_addr[hfpcd_pkg::ADDR_W-1]))
        else $error("store write hit the bank being emitted");

    a_bad_sum_mask: assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && !res.checksum_ok) |-> (res.change_mask == '0))
        else $error("change mask set with bad checksum");

    a_start_flips: assert property (@(posedge clk) disable iff (!rst_n)
        req.start |=> (wr_bank_reg != $past(wr_bank_reg) && pos_reg == hfpcd_pkg::POS_HUNT))
        else $error("frame completion did not swap banks");

endmodule

// ----- design/hfpcd_emitter.sv -----
// walks one finished frame bank of the byte store and drives the result channel
// depends on hfpcd_pkg and hfpcd_res_if; the store read register lives in the top level
module hfpcd_emitter
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  hfpcd_pkg::emit_req_t           req,
    output logic                           busy,
    output logic                           rd_en,
    output logic [hfpcd_pkg::ADDR_W-1:0]   rd_addr,
    input  logic [7:0]                     rd_data,
    hfpcd_res_if.source                    res
);

    logic                           active_reg;
    logic                           bank_reg;
    logic                           ok_reg;
    logic [hfpcd_pkg::MASK_W-1:0]   mask_reg;
    logic [hfpcd_pkg::IDX_W-1:0]    cnt_reg;
    logic                           out_valid_reg;
    logic [hfpcd_pkg::IDX_W-1:0]    idx_reg;
    logic                           last_reg;
    logic                           okout_reg;
    logic [hfpcd_pkg::MASK_W-1:0]   maskout_reg;
    logic                           issue;
    logic                           is_last;

    // while active, a read is issued whenever the output register frees up next edge
    assign issue   = active_reg && (!out_valid_reg || res.ready);
    assign is_last = (cnt_reg == hfpcd_pkg::IDX_LAST);
    assign busy    = active_reg;
    assign rd_en   = issue;
    assign rd_addr = {bank_reg, cnt_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (req.start)
            begin
                active_reg <= 1'b1;
                cnt_reg    <= '0;
            end
            else if (issue)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (is_last)
                begin
                    active_reg <= 1'b0;
                end
            end
            if (issue)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (res.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            bank_reg <= req.bank;
            ok_reg   <= req.ok;
            mask_reg <= req.mask;
        end
        if (issue)
        begin
            idx_reg     <= cnt_reg;
            last_reg    <= is_last;
            okout_reg   <= is_last && ok_reg;
            maskout_reg <= is_last ? mask_reg : '0;
        end
    end

    assign res.valid         = out_valid_reg;
    assign res.byte_index    = idx_reg;
    assign res.payload_byte  = rd_data;
    assign res.last_of_frame = last_reg;
    assign res.checksum_ok   = okout_reg;
    assign res.change_mask   = maskout_reg;

    a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
        req.start |-> !active_reg)
        else $error("emission started while a frame was still being emitted");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !res.ready) |=> (out_valid_reg && $stable(rd_data)))
        else $error("stalled result beat changed");

endmodule
